[hdl/dtn_pkg.sv]
// shared widths, unit constants and duration types for the duration normaliser
package dtn_pkg;

    localparam int FIELD_W = 21;

    localparam int MS_PER_SEC   = 1000;
    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;

    localparam int MS_W   = 10;
    localparam int SEC_W  = 6;
    localparam int MIN_W  = 6;
    localparam int HOUR_W = 5;

    // signed width of the carry chain values and of the carried day count
    localparam int CARRY_W = 23;

    localparam int MAG_W = 48;
    localparam int NUM_W = MAG_W + 1;

    localparam int PIPE_DEPTH = 9;

    typedef struct packed {
        logic                      neg;
        logic signed [FIELD_W-1:0] day;
        logic signed [FIELD_W-1:0] hour;
        logic signed [FIELD_W-1:0] minute;
        logic signed [FIELD_W-1:0] second;
        logic signed [FIELD_W-1:0] milli;
    } dur_t;

    localparam int DUR_W = $bits(dur_t);
    localparam int IN_W  = ((2 * DUR_W + 7) / 8) * 8;

    // floor-normalised fields before the sign fold
    typedef struct packed {
        logic signed [CARRY_W-1:0] day;
        logic [HOUR_W-1:0]         hour;
        logic [MIN_W-1:0]          minute;
        logic [SEC_W-1:0]          second;
        logic [MS_W-1:0]           milli;
    } carry_t;

    localparam int OUT_BITS = 1 + FIELD_W + HOUR_W + MIN_W + SEC_W + MS_W + 3 + NUM_W + MAG_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

[hdl/day_time_duration_normalize_compare_core.sv]
// top level: duration normaliser, comparator and ratio stream core
//
// Takes one word per cycle holding two raw day/hour/minute/second/millisecond
// durations with sign flags and returns normalised A, the less/greater/equal
// flags of A against B and the ratio A/B as signed and unsigned millisecond
// totals. With m_tready held high a new word is taken every cycle. There are
// nine register stages, the first loaded at the accepting edge: the carry chain
// takes two for each of the four reciprocal floor divisions and the sign fold
// goes into the output register; the millisecond totals take four multiply-add
// stages and a magnitude stage, and the comparison follows them.
// Every stage has its own valid bit and moves up whenever the stage after it
// has room, so empty stages close up under back-pressure. A zero total keeps
// its sign flag, so a negative zero compares below a positive zero.
module day_time_duration_normalize_compare_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // a_negative, a_day, a_hour, a_minute, a_second, a_milli,
    // b_negative, b_day, b_hour, b_minute, b_second, b_milli, zero pad
    input  logic [dtn_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // norm_negative, norm_day, norm_hour, norm_minute, norm_second, norm_milli,
    // is_less, is_greater, is_equal, ratio_numerator, ratio_denominator, zero pad
    output logic [dtn_pkg::OUT_W-1:0] m_tdata
);
    import dtn_pkg::*;

    typedef struct packed {
        logic               neg;
        logic               less;
        logic               greater;
        logic               equal;
        logic [NUM_W-1:0]   num;
        logic [MAG_W-1:0]   den;
    } cmp_t;

    function automatic dur_t get_dur(input logic [IN_W-1:0] bus, input int base);
        dur_t d;
        d.neg    = bus[base];
        d.day    = bus[base + 1 +: FIELD_W];
        d.hour   = bus[base + 1 + FIELD_W +: FIELD_W];
        d.minute = bus[base + 1 + 2 * FIELD_W +: FIELD_W];
        d.second = bus[base + 1 + 3 * FIELD_W +: FIELD_W];
        d.milli  = bus[base + 1 + 4 * FIELD_W +: FIELD_W];
        return d;
    endfunction

    logic [PIPE_DEPTH-1:0] valid_reg, valid_next, en;
    dur_t                  dur_a, dur_b;
    logic                  a_neg, b_neg;
    logic [MAG_W-1:0]      a_mag, b_mag;
    carry_t                cr;
    cmp_t                  cmp6_reg, cmp7_reg, cmp8_reg, cmp6_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    // sign fold terms
    logic                  fold, b1, b2, b3, b4;
    logic [SEC_W:0]        sec_sum;
    logic [MIN_W:0]        min_sum;
    logic [HOUR_W:0]       hr_sum;
    logic [MS_W-1:0]       ms_o;
    logic [SEC_W-1:0]      sec_o;
    logic [MIN_W-1:0]      min_o;
    logic [HOUR_W-1:0]     hr_o;
    logic signed [CARRY_W-1:0] day_o;

    // per-stage advance: a stage loads when empty or when its successor loads
    always_comb begin
        en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    assign dur_a = get_dur(s_tdata, 0);
    assign dur_b = get_dur(s_tdata, DUR_W);

    dtn_total u_total_a (
        .aclk (aclk),
        .en   (en),
        .dur  (dur_a),
        .neg  (a_neg),
        .mag  (a_mag)
    );

    dtn_total u_total_b (
        .aclk (aclk),
        .en   (en),
        .dur  (dur_b),
        .neg  (b_neg),
        .mag  (b_mag)
    );

    dtn_carry u_carry (
        .aclk  (aclk),
        .en    (en),
        .dur   (dur_a),
        .carry (cr)
    );

    always_comb begin
        cmp6_next.neg   = a_neg;
        cmp6_next.equal = (a_neg == b_neg) && (a_mag == b_mag);
        if (a_neg != b_neg) begin
            cmp6_next.less    = a_neg;
            cmp6_next.greater = b_neg;
            cmp6_next.num     = NUM_W'(0) - NUM_W'(a_mag);
        end else if (a_neg) begin
            cmp6_next.less    = b_mag < a_mag;
            cmp6_next.greater = b_mag > a_mag;
            cmp6_next.num     = NUM_W'(a_mag);
        end else begin
            cmp6_next.less    = a_mag < b_mag;
            cmp6_next.greater = a_mag > b_mag;
            cmp6_next.num     = NUM_W'(a_mag);
        end
        cmp6_next.den = b_mag;
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            cmp6_reg <= cmp6_next;
        end
        if (en[6]) begin
            cmp7_reg <= cmp6_reg;
        end
        if (en[7]) begin
            cmp8_reg <= cmp7_reg;
        end
    end

    // negative day count: magnitude is the borrow-complement of the lower fields
    always_comb begin
        fold    = cr.day[CARRY_W-1];
        b1      = cr.milli != '0;
        sec_sum = (SEC_W+1)'(cr.second) + (SEC_W+1)'(b1);
        b2      = sec_sum != '0;
        min_sum = (MIN_W+1)'(cr.minute) + (MIN_W+1)'(b2);
        b3      = min_sum != '0;
        hr_sum  = (HOUR_W+1)'(cr.hour) + (HOUR_W+1)'(b3);
        b4      = hr_sum != '0;
        if (fold) begin
            ms_o  = b1 ? MS_W'(MS_PER_SEC) - cr.milli : '0;
            sec_o = b2 ? SEC_W'((SEC_W+1)'(SEC_PER_MIN) - sec_sum) : '0;
            min_o = b3 ? MIN_W'((MIN_W+1)'(MIN_PER_HOUR) - min_sum) : '0;
            hr_o  = b4 ? HOUR_W'((HOUR_W+1)'(HOUR_PER_DAY) - hr_sum) : '0;
            day_o = CARRY_W'(0) - cr.day - CARRY_W'(b4);
        end else begin
            ms_o  = cr.milli;
            sec_o = cr.second;
            min_o = cr.minute;
            hr_o  = cr.hour;
            day_o = cr.day;
        end
        m_tdata_next = {(OUT_W - OUT_BITS)'(0), cmp8_reg.den, cmp8_reg.num,
                        cmp8_reg.equal, cmp8_reg.greater, cmp8_reg.less,
                        ms_o, sec_o, min_o, hr_o, day_o[FIELD_W-1:0], cmp8_reg.neg};
    end

    always_ff @(posedge aclk) begin
        if (en[PIPE_DEPTH-1]) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

[hdl/dtn_total.sv]
// five-stage pipeline that folds one raw duration into a signed millisecond total
module dtn_total (
    input  logic                              aclk,
    input  logic [dtn_pkg::PIPE_DEPTH-1:0]    en,
    input  dtn_pkg::dur_t                     dur,
    output logic                              neg,
    output logic [dtn_pkg::MAG_W-1:0]         mag
);
    import dtn_pkg::*;

    localparam int P1_W = 27;
    localparam int P2_W = 33;
    localparam int P3_W = 39;

    logic                      neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic signed [P1_W-1:0]    p1_reg, p1_next;
    logic signed [P2_W-1:0]    p2_reg, p2_next;
    logic signed [P3_W-1:0]    p3_reg, p3_next;
    logic signed [NUM_W-1:0]   p4_reg, p4_next;
    logic [MAG_W-1:0]          mag5_reg, mag5_next;
    logic signed [FIELD_W-1:0] min1_reg, sec1_reg, sec2_reg, ms1_reg, ms2_reg, ms3_reg;

    assign p1_next = P1_W'($signed(dur.day)) * P1_W'(HOUR_PER_DAY)
                   + P1_W'($signed(dur.hour));
    assign p2_next = P2_W'(p1_reg) * P2_W'(MIN_PER_HOUR) + P2_W'(min1_reg);
    assign p3_next = P3_W'(p2_reg) * P3_W'(SEC_PER_MIN) + P3_W'(sec2_reg);
    assign p4_next = NUM_W'(p3_reg) * NUM_W'(MS_PER_SEC) + NUM_W'(ms3_reg);
    assign mag5_next = p4_reg[NUM_W-1] ? MAG_W'(NUM_W'(0) - p4_reg) : MAG_W'(p4_reg);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p1_reg   <= p1_next;
            neg1_reg <= dur.neg;
            min1_reg <= dur.minute;
            sec1_reg <= dur.second;
            ms1_reg  <= dur.milli;
        end
        if (en[1]) begin
            p2_reg   <= p2_next;
            neg2_reg <= neg1_reg;
            sec2_reg <= sec1_reg;
            ms2_reg  <= ms1_reg;
        end
        if (en[2]) begin
            p3_reg   <= p3_next;
            neg3_reg <= neg2_reg;
            ms3_reg  <= ms2_reg;
        end
        if (en[3]) begin
            p4_reg   <= p4_next;
            neg4_reg <= neg3_reg;
        end
        if (en[4]) begin
            mag5_reg <= mag5_next;
            // a negative total flips the flag
            neg5_reg <= neg4_reg ^ p4_reg[NUM_W-1];
        end
    end

    assign neg = neg5_reg;
    assign mag = mag5_reg;

endmodule

[hdl/dtn_carry.sv]
// eight-stage upward carry chain with floor remainders at 1000, 60, 60 and 24
module dtn_carry (
    input  logic                            aclk,
    input  logic [dtn_pkg::PIPE_DEPTH-1:0]  en,
    input  dtn_pkg::dur_t                   dur,
    output dtn_pkg::carry_t                 carry
);
    import dtn_pkg::*;

    // floor division by reciprocal: values are biased positive below 2^24
    localparam int BIASED_W    = 24;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 34;
    localparam int QUOT_W      = 21;
    localparam int BIAS_SPAN   = 1 << 22;

    localparam int K_MS  = (BIAS_SPAN + MS_PER_SEC - 1) / MS_PER_SEC;
    localparam int K_SEC = (BIAS_SPAN + SEC_PER_MIN - 1) / SEC_PER_MIN;
    localparam int K_MIN = (BIAS_SPAN + MIN_PER_HOUR - 1) / MIN_PER_HOUR;
    localparam int K_HR  = (BIAS_SPAN + HOUR_PER_DAY - 1) / HOUR_PER_DAY;

    localparam logic [BIASED_W-1:0] BIAS_MS  = BIASED_W'(K_MS * MS_PER_SEC);
    localparam logic [BIASED_W-1:0] BIAS_SEC = BIASED_W'(K_SEC * SEC_PER_MIN);
    localparam logic [BIASED_W-1:0] BIAS_MIN = BIASED_W'(K_MIN * MIN_PER_HOUR);
    localparam logic [BIASED_W-1:0] BIAS_HR  = BIASED_W'(K_HR * HOUR_PER_DAY);

    localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_MS  =
        RECIP_W'((RECIP_ONE + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));
    localparam logic [RECIP_W-1:0] RECIP_SEC =
        RECIP_W'((RECIP_ONE + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
    localparam logic [RECIP_W-1:0] RECIP_MIN =
        RECIP_W'((RECIP_ONE + 64'(MIN_PER_HOUR) - 64'd1) / 64'(MIN_PER_HOUR));
    localparam logic [RECIP_W-1:0] RECIP_HR  =
        RECIP_W'((RECIP_ONE + 64'(HOUR_PER_DAY) - 64'd1) / 64'(HOUR_PER_DAY));

    function automatic logic [BIASED_W-1:0] biased(input logic signed [CARRY_W-1:0] x,
                                                   input logic [BIASED_W-1:0] bias);
        return BIASED_W'(x) + bias;
    endfunction

    function automatic logic [QUOT_W-1:0] quot(input logic [BIASED_W-1:0] u,
                                               input logic [RECIP_W-1:0] recip);
        logic [BIASED_W+RECIP_W-1:0] prod;
        prod = (BIASED_W+RECIP_W)'(u) * (BIASED_W+RECIP_W)'(recip);
        return prod[RECIP_SHIFT +: QUOT_W];
    endfunction

    function automatic logic [BIASED_W-1:0] remain(input logic [BIASED_W-1:0] u,
                                                   input logic [QUOT_W-1:0] q,
                                                   input logic [BIASED_W-1:0] divisor);
        return u - BIASED_W'(q) * divisor;
    endfunction

    // next field plus floor quotient, bias taken back out
    function automatic logic signed [CARRY_W-1:0] carry_in(
        input logic signed [FIELD_W-1:0] x, input logic [QUOT_W-1:0] q, input int k);
        return CARRY_W'(x) + CARRY_W'(q) - CARRY_W'(k);
    endfunction

    logic [BIASED_W-1:0]       u0_reg, u1_reg, u2_reg, u3_reg;
    logic [BIASED_W-1:0]       u0_next, u1_next, u2_next, u3_next;
    logic [QUOT_W-1:0]         q0_reg, q1_reg, q2_reg, q3_reg;
    logic signed [CARRY_W-1:0] xs2_reg, xm4_reg, xh6_reg;
    logic signed [CARRY_W-1:0] xs2_next, xm4_next, xh6_next, day8_next;
    logic [MS_W-1:0]           ms_rem_next;
    logic [SEC_W-1:0]          sec_rem_next;
    logic [MIN_W-1:0]          min_rem_next;
    logic [HOUR_W-1:0]         hr_rem_next;
    logic [MS_W-1:0]           rms2_reg, rms3_reg, rms4_reg, rms5_reg, rms6_reg, rms7_reg;
    logic [SEC_W-1:0]          rs4_reg, rs5_reg, rs6_reg, rs7_reg;
    logic [MIN_W-1:0]          rm6_reg, rm7_reg;
    logic signed [FIELD_W-1:0] day1_reg, day2_reg, day3_reg, day4_reg, day5_reg;
    logic signed [FIELD_W-1:0] day6_reg, day7_reg;
    logic signed [FIELD_W-1:0] hour1_reg, hour2_reg, hour3_reg, hour4_reg, hour5_reg;
    logic signed [FIELD_W-1:0] min1_reg, min2_reg, min3_reg, sec1_reg;
    carry_t                    carry_reg;

    assign u0_next      = biased(CARRY_W'($signed(dur.milli)), BIAS_MS);
    assign ms_rem_next  = MS_W'(remain(u0_reg, q0_reg, BIASED_W'(MS_PER_SEC)));
    assign xs2_next     = carry_in(sec1_reg, q0_reg, K_MS);
    assign u1_next      = biased(xs2_reg, BIAS_SEC);
    assign sec_rem_next = SEC_W'(remain(u1_reg, q1_reg, BIASED_W'(SEC_PER_MIN)));
    assign xm4_next     = carry_in(min3_reg, q1_reg, K_SEC);
    assign u2_next      = biased(xm4_reg, BIAS_MIN);
    assign min_rem_next = MIN_W'(remain(u2_reg, q2_reg, BIASED_W'(MIN_PER_HOUR)));
    assign xh6_next     = carry_in(hour5_reg, q2_reg, K_MIN);
    assign u3_next      = biased(xh6_reg, BIAS_HR);
    assign hr_rem_next  = HOUR_W'(remain(u3_reg, q3_reg, BIASED_W'(HOUR_PER_DAY)));
    assign day8_next    = carry_in(day7_reg, q3_reg, K_HR);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            u0_reg    <= u0_next;
            q0_reg    <= quot(u0_next, RECIP_MS);
            day1_reg  <= dur.day;
            hour1_reg <= dur.hour;
            min1_reg  <= dur.minute;
            sec1_reg  <= dur.second;
        end
        if (en[1]) begin
            rms2_reg  <= ms_rem_next;
            xs2_reg   <= xs2_next;
            day2_reg  <= day1_reg;
            hour2_reg <= hour1_reg;
            min2_reg  <= min1_reg;
        end
        if (en[2]) begin
            u1_reg    <= u1_next;
            q1_reg    <= quot(u1_next, RECIP_SEC);
            rms3_reg  <= rms2_reg;
            day3_reg  <= day2_reg;
            hour3_reg <= hour2_reg;
            min3_reg  <= min2_reg;
        end
        if (en[3]) begin
            rs4_reg   <= sec_rem_next;
            xm4_reg   <= xm4_next;
            rms4_reg  <= rms3_reg;
            day4_reg  <= day3_reg;
            hour4_reg <= hour3_reg;
        end
        if (en[4]) begin
            u2_reg    <= u2_next;
            q2_reg    <= quot(u2_next, RECIP_MIN);
            rms5_reg  <= rms4_reg;
            rs5_reg   <= rs4_reg;
            day5_reg  <= day4_reg;
            hour5_reg <= hour4_reg;
        end
        if (en[5]) begin
            rm6_reg   <= min_rem_next;
            xh6_reg   <= xh6_next;
            rms6_reg  <= rms5_reg;
            rs6_reg   <= rs5_reg;
            day6_reg  <= day5_reg;
        end
        if (en[6]) begin
            u3_reg    <= u3_next;
            q3_reg    <= quot(u3_next, RECIP_HR);
            rms7_reg  <= rms6_reg;
            rs7_reg   <= rs6_reg;
            rm7_reg   <= rm6_reg;
            day7_reg  <= day6_reg;
        end
        if (en[7]) begin
            carry_reg.day    <= day8_next;
            carry_reg.hour   <= hr_rem_next;
            carry_reg.minute <= rm7_reg;
            carry_reg.second <= rs7_reg;
            carry_reg.milli  <= rms7_reg;
        end
    end

    assign carry = carry_reg;

endmodule

[hdl/dtn_checker.sv]
// port-level checks on the normaliser output stream, bound to the top level
module dtn_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [dtn_pkg::OUT_W-1:0] m_tdata
);
    import dtn_pkg::*;

    localparam int HOUR_LSB = 1 + FIELD_W;
    localparam int MIN_LSB  = HOUR_LSB + HOUR_W;
    localparam int SEC_LSB  = MIN_LSB + MIN_W;
    localparam int MS_LSB   = SEC_LSB + SEC_W;
    localparam int LESS_BIT = MS_LSB + MS_W;
    localparam int EQ_BIT   = LESS_BIT + 2;
    localparam int NUM_LSB  = LESS_BIT + 3;
    localparam int DEN_LSB  = NUM_LSB + NUM_W;

    // a held word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

    a_one_relation: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[EQ_BIT:LESS_BIT]))
        else $error("less, greater and equal not exclusive");

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[HOUR_LSB +: HOUR_W] < HOUR_W'(HOUR_PER_DAY))
                  && (m_tdata[MIN_LSB +: MIN_W] < MIN_W'(MIN_PER_HOUR))
                  && (m_tdata[SEC_LSB +: SEC_W] < SEC_W'(SEC_PER_MIN))
                  && (m_tdata[MS_LSB +: MS_W] < MS_W'(MS_PER_SEC)))
        else $error("normalised field out of range");

    // equal durations give equal ratio terms with a non-negative numerator
    a_equal_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[EQ_BIT] |->
            !m_tdata[NUM_LSB + NUM_W - 1]
            && (m_tdata[NUM_LSB +: MAG_W] == m_tdata[DEN_LSB +: MAG_W]))
        else $error("equal flag with unequal ratio terms");

endmodule

bind day_time_duration_normalize_compare_core dtn_checker u_dtn_checker (.*);

[dv/day_time_duration_normalize_compare_core_checker.sv]
`timescale 1ns / 100ps
// checker for the duration normaliser: predicts each result word and compares it field by field
module day_time_duration_normalize_compare_core_checker (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [dtn_pkg::IN_W-1:0]  s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [dtn_pkg::OUT_W-1:0] m_tdata,
    output int                       mismatches,
    output int                       pending,
    output int                       checked
);
    import dtn_pkg::*;

    localparam int DUR_BITS = 1 + 5 * FIELD_W;

    // lowest field of the result word last, so the struct maps straight onto m_tdata
    typedef struct packed {
        logic [MAG_W-1:0]   den;
        logic [NUM_W-1:0]   num;
        logic               equal;
        logic               greater;
        logic               less;
        logic [MS_W-1:0]    milli;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [FIELD_W-1:0] day;
        logic               neg;
    } norm_result_t;

    norm_result_t expected_norm_q[$];

    // day is the lowest field, milli the highest
    function automatic longint signed_total_ms(input logic [5*FIELD_W-1:0] f);
        longint t;
        t = longint'($signed(f[0 +: FIELD_W]));
        t = t * HOUR_PER_DAY + longint'($signed(f[FIELD_W +: FIELD_W]));
        t = t * MIN_PER_HOUR + longint'($signed(f[2*FIELD_W +: FIELD_W]));
        t = t * SEC_PER_MIN + longint'($signed(f[3*FIELD_W +: FIELD_W]));
        t = t * MS_PER_SEC + longint'($signed(f[4*FIELD_W +: FIELD_W]));
        return t;
    endfunction

    function automatic norm_result_t normalize_and_compare(input logic [IN_W-1:0] w);
        longint ta, tb, ma, mb, r, num;
        logic an, bn;
        norm_result_t res;
        ta = signed_total_ms(w[1 +: 5*FIELD_W]);
        tb = signed_total_ms(w[DUR_BITS+1 +: 5*FIELD_W]);
        // a negative total flips the flag and keeps the magnitude
        an = w[0] ^ (ta < 0);
        bn = w[DUR_BITS] ^ (tb < 0);
        ma = (ta < 0) ? -ta : ta;
        mb = (tb < 0) ? -tb : tb;
        r = ma;
        res.milli  = MS_W'(r % MS_PER_SEC);
        r = r / MS_PER_SEC;
        res.second = SEC_W'(r % SEC_PER_MIN);
        r = r / SEC_PER_MIN;
        res.minute = MIN_W'(r % MIN_PER_HOUR);
        r = r / MIN_PER_HOUR;
        res.hour   = HOUR_W'(r % HOUR_PER_DAY);
        r = r / HOUR_PER_DAY;
        res.day    = r[FIELD_W-1:0];
        res.neg    = an;
        if (an != bn) begin
            res.less    = an;
            res.greater = bn;
        end else if (an) begin
            res.less    = mb < ma;
            res.greater = mb > ma;
        end else begin
            res.less    = ma < mb;
            res.greater = ma > mb;
        end
        // signed zero: flags must match for equality
        res.equal = (an == bn) && (ma == mb);
        num = (an != bn) ? -ma : ma;
        res.num = num[NUM_W-1:0];
        res.den = mb[MAG_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        norm_result_t want, got;
        if (!aresetn) begin
            expected_norm_q.delete();
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = norm_result_t'(m_tdata[$bits(norm_result_t)-1:0]);
                if (expected_norm_q.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_norm_q.pop_front();
                    check_field("norm_negative", 64'(want.neg), 64'(got.neg));
                    check_field("norm_day", 64'(want.day), 64'(got.day));
                    check_field("norm_hour", 64'(want.hour), 64'(got.hour));
                    check_field("norm_minute", 64'(want.minute), 64'(got.minute));
                    check_field("norm_second", 64'(want.second), 64'(got.second));
                    check_field("norm_milli", 64'(want.milli), 64'(got.milli));
                    check_field("is_less", 64'(want.less), 64'(got.less));
                    check_field("is_greater", 64'(want.greater), 64'(got.greater));
                    check_field("is_equal", 64'(want.equal), 64'(got.equal));
                    check_field("ratio_numerator", 64'(want.num), 64'(got.num));
                    check_field("ratio_denominator", 64'(want.den), 64'(got.den));
                    checked++;
                end
            end
            if (s_tvalid && s_tready)
                expected_norm_q.push_back(normalize_and_compare(s_tdata));
            pending <= expected_norm_q.size();
        end
    end

endmodule

[dv/day_time_duration_normalize_compare_core_tb.sv]
`timescale 1ns / 100ps
// testbench top: clock, reset, bursty duration stimulus, output stalls and the verdict
module day_time_duration_normalize_compare_core_tb;
    import dtn_pkg::*;

    localparam int DUR_BITS     = 1 + 5 * FIELD_W;
    localparam int RANDOM_WORDS = 1035;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAXV         = 1048575;
    localparam int MINV         = -1048576;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;
    typedef enum int {DK_FULL, DK_CLOCK, DK_SMALL, DK_ZERO, DK_EDGE} dur_kind_t;
    typedef enum int {BK_FREE, BK_COPY, BK_SHIFTED, BK_NEAR, BK_ZERO} b_kind_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    int mismatches, pending, checked;
    int words_sent;
    bit hold_req;

    day_time_duration_normalize_compare_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    day_time_duration_normalize_compare_core_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [DUR_BITS-1:0] pack_dur(input bit n, input int d, input int h,
                                                     input int mi, input int s, input int ms);
        logic [DUR_BITS-1:0] v;
        v[0] = n;
        v[1 +: FIELD_W]             = d[FIELD_W-1:0];
        v[1 + FIELD_W +: FIELD_W]   = h[FIELD_W-1:0];
        v[1 + 2*FIELD_W +: FIELD_W] = mi[FIELD_W-1:0];
        v[1 + 3*FIELD_W +: FIELD_W] = s[FIELD_W-1:0];
        v[1 + 4*FIELD_W +: FIELD_W] = ms[FIELD_W-1:0];
        return v;
    endfunction

    function automatic logic [IN_W-1:0] pair(input logic [DUR_BITS-1:0] a,
                                             input logic [DUR_BITS-1:0] b);
        logic [IN_W-1:0] w;
        w = '0;
        w[0 +: DUR_BITS]        = a;
        w[DUR_BITS +: DUR_BITS] = b;
        return w;
    endfunction

    function automatic logic [DUR_BITS-1:0] rand_dur(input dur_kind_t kind);
        int f[5];
        bit n;
        n = 1'($urandom_range(0, 1));
        for (int k = 0; k < 5; k++) begin
            case (kind)
                DK_FULL:  f[k] = $urandom;
                DK_SMALL: f[k] = int'($urandom_range(0, 400)) - 200;
                DK_ZERO:  f[k] = 0;
                DK_EDGE: begin
                    case ($urandom_range(0, 4))
                        0:       f[k] = MINV;
                        1:       f[k] = MAXV;
                        2:       f[k] = 0;
                        3:       f[k] = -1;
                        default: f[k] = 1;
                    endcase
                end
                default: f[k] = 0;
            endcase
        end
        if (kind == DK_CLOCK) begin
            f[0] = $urandom_range(0, 3000);
            if ($urandom_range(0, 2) == 0)
                f[0] = -f[0];
            f[1] = $urandom_range(0, 23);
            f[2] = $urandom_range(0, 59);
            f[3] = $urandom_range(0, 59);
            f[4] = $urandom_range(0, 999);
        end
        return pack_dur(n, f[0], f[1], f[2], f[3], f[4]);
    endfunction

    function automatic logic [IN_W-1:0] make_word();
        logic [DUR_BITS-1:0] a, b;
        int pick;
        dur_kind_t akind;
        b_kind_t bkind;
        pick = $urandom_range(0, 99);
        akind = (pick < 30) ? DK_FULL : (pick < 65) ? DK_CLOCK : (pick < 85) ? DK_SMALL :
                (pick < 90) ? DK_ZERO : DK_EDGE;
        a = rand_dur(akind);
        pick = $urandom_range(0, 99);
        bkind = (pick < 40) ? BK_FREE : (pick < 60) ? BK_COPY : (pick < 75) ? BK_SHIFTED :
                (pick < 90) ? BK_NEAR : BK_ZERO;
        b = a;
        case (bkind)
            BK_FREE: b = rand_dur(dur_kind_t'($urandom_range(0, 4)));
            BK_COPY: begin
                if ($urandom_range(0, 3) == 0)
                    b[0] = ~a[0];
            end
            BK_SHIFTED: begin
                // same total, one minute moved down into the seconds
                b[1 + 2*FIELD_W +: FIELD_W] = FIELD_W'(a[1 + 2*FIELD_W +: FIELD_W] - 1);
                b[1 + 3*FIELD_W +: FIELD_W] = FIELD_W'(a[1 + 3*FIELD_W +: FIELD_W] + 60);
            end
            BK_NEAR: begin
                if ($urandom_range(0, 1))
                    b[1 + 4*FIELD_W +: FIELD_W] = FIELD_W'(a[1 + 4*FIELD_W +: FIELD_W] + 1);
                else
                    b[1 + 4*FIELD_W +: FIELD_W] = FIELD_W'(a[1 + 4*FIELD_W +: FIELD_W] - 1);
            end
            BK_ZERO: b = pack_dur(1'($urandom_range(0, 1)), 0, 0, 0, 0, 0);
            default: b = a;
        endcase
        return pair(a, b);
    endfunction

    task automatic send_word(input logic [IN_W-1:0] w);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic pause_input(input int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= make_word();
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge aclk);
    endtask

    // output side: stretches of random stall patterns, plus one long hold-off on request
    initial begin : receiver
        rx_mode_t mode;
        int stretch, hold_left;
        bit hold_taken;
        m_tready   = 1'b0;
        mode       = RX_ALWAYS;
        stretch    = 0;
        hold_left  = 0;
        hold_taken = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stretch == 0) begin
                mode    = rx_mode_t'($urandom_range(0, 3));
                stretch = $urandom_range(8, 80);
            end
            stretch--;
            if (hold_req && !hold_taken) begin
                hold_taken = 1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ends the run when neither side has moved a word for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no word moved for %0d cycles", STALL_LIMIT);
        $display("day_time_duration_normalize_compare_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int rnd, burst, directed_words;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        hold_req   = 0;
        words_sent = 0;
        rnd        = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // signed zeros in every flag combination
        send_word(pair(pack_dur(0, 0, 0, 0, 0, 0), pack_dur(0, 0, 0, 0, 0, 0)));
        send_word(pair(pack_dur(1, 0, 0, 0, 0, 0), pack_dur(0, 0, 0, 0, 0, 0)));
        send_word(pair(pack_dur(0, 0, 0, 0, 0, 0), pack_dur(1, 0, 0, 0, 0, 0)));
        send_word(pair(pack_dur(1, 0, 0, 0, 0, 0), pack_dur(1, 0, 0, 0, 0, 0)));
        // field extremes
        send_word(pair(pack_dur(0, MAXV, MAXV, MAXV, MAXV, MAXV),
                       pack_dur(0, MAXV, MAXV, MAXV, MAXV, MAXV)));
        send_word(pair(pack_dur(0, MINV, MINV, MINV, MINV, MINV),
                       pack_dur(1, MINV, MINV, MINV, MINV, MINV)));
        send_word(pair(pack_dur(0, MAXV, MAXV, MAXV, MAXV, MAXV),
                       pack_dur(0, MINV, MINV, MINV, MINV, MINV)));
        send_word(pair(pack_dur(1, MINV, MINV, MINV, MINV, MINV),
                       pack_dur(1, MAXV, MAXV, MAXV, MAXV, MAXV)));
        send_word(pair(pack_dur(1, 'h155555, 'h0AAAAA, 'h155555, 'h0AAAAA, 'h155555),
                       pack_dur(0, 'h0AAAAA, 'h155555, 'h0AAAAA, 'h155555, 'h0AAAAA)));
        // zero divisor
        send_word(pair(pack_dur(0, 0, 0, 0, 0, 1), pack_dur(0, 0, 0, 0, 0, 0)));
        // negative total flips the flag
        send_word(pair(pack_dur(0, 0, 0, 0, 0, -1), pack_dur(0, 0, 0, 0, 0, 1)));
        send_word(pair(pack_dur(0, -3, 5, 0, 0, 0), pack_dur(1, 2, 19, 0, 0, 0)));
        // carries in every field, equal after normalising
        send_word(pair(pack_dur(0, 0, 25, 61, 61, 1001), pack_dur(0, 1, 2, 2, 2, 1)));
        send_word(pair(pack_dur(0, 0, 0, 0, 0, 2000), pack_dur(0, 0, 0, 0, 2, 0)));
        send_word(pair(pack_dur(0, 1, 0, 0, 0, 0), pack_dur(0, 0, 24, 0, 0, 0)));
        // both negative: smaller magnitude is the greater
        send_word(pair(pack_dur(1, 0, 0, 0, 5, 0), pack_dur(1, 0, 0, 0, 7, 0)));
        send_word(pair(pack_dur(1, 0, 0, 0, 7, 0), pack_dur(1, 0, 0, 0, 5, 0)));
        directed_words = words_sent;
        pause_input(1);
        wait_drained();

        while (rnd < RANDOM_WORDS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
            for (int j = 0; j < burst && rnd < RANDOM_WORDS; j++) begin
                if (rnd == 300)
                    hold_req = 1;
                if (rnd == 650) begin
                    pause_input(1);
                    wait_drained();
                end
                send_word(make_word());
                rnd++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_input($urandom_range(1, 10));
        end
        pause_input(1);
        wait_drained();
        repeat (3 * PIPE_DEPTH) @(posedge aclk);

        $display("covered %0d words (%0d directed) in random bursts, with output stalls, a %0d-cycle",
                 words_sent, directed_words, HOLD_CYCLES);
        $display("output hold-off and a full drain pause; %0d results compared, %0d mismatches",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("day_time_duration_normalize_compare_core regression: pass");
        end else begin
            $display("day_time_duration_normalize_compare_core regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
hdl/dtn_pkg.sv
hdl/dtn_total.sv
hdl/dtn_carry.sv
hdl/day_time_duration_normalize_compare_core.sv
hdl/dtn_checker.sv
dv/day_time_duration_normalize_compare_core_checker.sv
dv/day_time_duration_normalize_compare_core_tb.sv
